// ----- sv/sine_square_waveform_generator_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sine/square waveform generator
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SINE_SQUARE_WAVEFORM_GENERATOR_MACROS_SVH
`define SINE_SQUARE_WAVEFORM_GENERATOR_MACROS_SVH

// same-cycle implication
`define SSWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/sswg_pkg.sv -----
// ----------------------------------------------------------------------------
// sswg_pkg
// Register map, reset values and quarter-wave sine generator function.
// ----------------------------------------------------------------------------
package sswg_pkg;

    localparam int unsigned SIN_C1    = 102944;
    localparam int unsigned SIN_C3    = 42334;
    localparam int unsigned SIN_C5    = 4926;
    localparam logic [16:0] DUTY_FULL = 17'd65536;
    localparam logic [16:0] QSIN_MAX  = 17'd65536;

    localparam int          REG_AW    = 4;
    localparam int          REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_WAVEFORM_KIND = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TUNING_WORD   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_DUTY_FRACTION = 2'd3;

    localparam logic        RST_WAVEFORM_KIND = 1'b0;
    localparam logic [31:0] RST_TUNING_WORD   = 32'd1;
    localparam logic [14:0] RST_AMPLITUDE     = 15'd32767;
    localparam logic [16:0] RST_DUTY_FRACTION = 17'd32768;

    // quarter sine of x in Q16 (0..65536 spans 0..pi/2), result in Q16
    function automatic logic [16:0] quarter_sine(input logic [16:0] x);
        logic [63:0] xw;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] s;
        xw = 64'(x);
        x2 = (xw * xw) >> 16;
        t  = 64'(SIN_C3) - ((x2 * 64'(SIN_C5)) >> 16);
        u  = 64'(SIN_C1) - ((x2 * t) >> 16);
        s  = (xw * u) >> 16;
        if (s > 64'(QSIN_MAX)) begin
            s = 64'(QSIN_MAX);
        end
        return s[16:0];
    endfunction

endpackage

// ----- sv/sine_square_waveform_generator.sv -----
// ----------------------------------------------------------------------------
// sine_square_waveform_generator
// Direct digital synthesis of a sine or square wave, one sample per request.
// ----------------------------------------------------------------------------
// Each input request is one sample tick carrying start_of_block; each gives
// exactly one signed sample on the output channel, in order.
// Both channels use valid/stall: a request moves when valid is high and stall
// is low. The phase accumulator advances by tuning_word on every request;
// a square-wave start_of_block restarts it from zero first. The two stages
// (table lookup, then the amplitude multiply and sign) take one request per
// clock while the output is not stalled.
// When the receiver stalls with a sample waiting, the whole pipeline holds
// and o_stall rises in the same cycle; no sample is lost or repeated.
// Synchronous active-low reset empties the pipeline, clears the phase to zero
// and loads register defaults: sine, tuning word 1, amplitude 32767,
// duty 32768. Write registers over the APB port only while idle (unenforced).
// ----------------------------------------------------------------------------
`include "sine_square_waveform_generator_macros.svh"

module sine_square_waveform_generator
    import sswg_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_start_of_block,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_sample,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [REG_AW-1:0]             paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int          QSIZE  = 1 << (SINE_TABLE_BITS - 2);
    localparam int          XW     = SINE_TABLE_BITS - 1;
    localparam int          XSHIFT = 16 - (SINE_TABLE_BITS - 2);
    localparam logic [31:0] SMAX   = 32'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    logic                  r_waveform_kind;
    logic [31:0]           r_tuning_word;
    logic [14:0]           r_amplitude;
    logic [16:0]           r_duty_fraction;
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] n_phase;

    logic                  r_v1;
    logic                  r_s1_sq;
    logic                  r_s1_neg;
    logic [16:0]           r_s1_qs;
    logic                  r_v2;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] n_sample;

    logic                       w_en;
    logic                       w_acc;
    logic                       w_wr;
    logic [REG_IDX_W-1:0]       w_idx;
    logic [PHASE_BITS-1:0]      w_tw;
    logic [PHASE_BITS-1:0]      w_base;
    logic [SINE_TABLE_BITS-1:0] w_tidx;
    logic [1:0]                 w_quad;
    logic [XW-1:0]              w_pos;
    logic [XW-1:0]              w_x;
    logic [16:0]                w_qsin [QSIZE+1];
    logic [15:0]                w_frac;
    logic [16:0]                w_duty;
    logic                       w_hi;
    logic [31:0]                w_amp32;
    logic [14:0]                w_amp_c;
    logic [31:0]                w_prod;
    logic [31:0]                w_mag_rnd;
    logic [31:0]                w_mag32;
    logic [SAMPLE_BITS-1:0]     w_mag;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign w_idx  = paddr[REG_AW-1:2];
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        case (w_idx)
            REG_WAVEFORM_KIND: prdata = 32'(r_waveform_kind);
            REG_TUNING_WORD:   prdata = r_tuning_word;
            REG_AMPLITUDE:     prdata = 32'(r_amplitude);
            REG_DUTY_FRACTION: prdata = 32'(r_duty_fraction);
            default:           prdata = 32'd0;
        endcase
    end

    // ---------------- handshake ----------------
    assign w_en    = !(r_v2 && i_stall);
    assign o_stall = !w_en;
    assign w_acc   = i_valid && w_en;
    assign o_valid = r_v2;
    assign o_sample = r_sample;

    // ---------------- phase ----------------
    assign w_tw    = PHASE_BITS'(r_tuning_word);
    assign w_base  = (r_waveform_kind && i_start_of_block) ? '0 : r_phase;
    assign n_phase = w_base + w_tw;

    // ---------------- stage 1: table lookup and duty compare ----------------
    for (genvar g = 0; g <= QSIZE; g++) begin : g_qsin
        assign w_qsin[g] = quarter_sine(17'(g << XSHIFT));
    end

    assign w_tidx = w_base[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign w_quad = w_tidx[SINE_TABLE_BITS-1 -: 2];
    assign w_pos  = {1'b0, w_tidx[SINE_TABLE_BITS-3:0]};
    assign w_x    = w_quad[0] ? (XW'(QSIZE) - w_pos) : w_pos;

    assign w_frac = w_base[PHASE_BITS-1 -: 16];
    assign w_duty = (r_duty_fraction > DUTY_FULL) ? DUTY_FULL : r_duty_fraction;
    assign w_hi   = {1'b0, w_frac} < w_duty;

    // ---------------- stage 2: scale, round, saturate, sign ----------------
    assign w_amp32   = 32'(r_amplitude);
    assign w_amp_c   = (w_amp32 > SMAX) ? SMAX[14:0] : r_amplitude;
    assign w_prod    = 32'(r_s1_qs) * 32'(w_amp_c);
    assign w_mag_rnd = (w_prod + 32'd32768) >> 16;
    assign w_mag32   = r_s1_sq ? 32'(w_amp_c)
                     : ((w_mag_rnd > SMAX) ? SMAX : w_mag_rnd);
    assign w_mag     = w_mag32[SAMPLE_BITS-1:0];
    assign n_sample  = r_s1_neg ? ('0 - w_mag) : w_mag;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform_kind <= RST_WAVEFORM_KIND;
            r_tuning_word   <= RST_TUNING_WORD;
            r_amplitude     <= RST_AMPLITUDE;
            r_duty_fraction <= RST_DUTY_FRACTION;
            r_phase         <= '0;
            r_v1            <= 1'b0;
            r_v2            <= 1'b0;
        end else begin
            if (w_wr) begin
                case (w_idx)
                    REG_WAVEFORM_KIND: r_waveform_kind <= pwdata[0];
                    REG_TUNING_WORD:   r_tuning_word   <= pwdata;
                    REG_AMPLITUDE:     r_amplitude     <= pwdata[14:0];
                    REG_DUTY_FRACTION: r_duty_fraction <= pwdata[16:0];
                    default: ;
                endcase
            end
            if (w_acc) begin
                r_phase <= n_phase;
            end
            if (w_en) begin
                r_v1 <= w_acc;
                r_v2 <= r_v1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_sq  <= r_waveform_kind;
            r_s1_neg <= r_waveform_kind ? !w_hi : w_quad[1];
            r_s1_qs  <= w_qsin[w_x];
            r_sample <= n_sample;
        end
    end

    // ---------------- assertions ----------------
    `SSWG_ASSERT_NOW(a_stall_only_when_full, i_clk, i_rst_n,
        o_stall, r_v2 && i_stall, "input stalled without a blocked sample")
    `SSWG_ASSERT_NEXT(a_stage_advance, i_clk, i_rst_n,
        r_v1 && w_en, r_v2, "stage 1 request lost on advance")
    `SSWG_ASSERT_NEXT(a_square_restart, i_clk, i_rst_n,
        w_acc && r_waveform_kind && i_start_of_block, r_phase == $past(w_tw),
        "square block start did not restart phase")
    `SSWG_ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n,
        !w_acc, $stable(r_phase), "phase moved without a request")

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Sine/square DDS generator: each tick request is checked against a bit-exact
// phase, sine and square predictor. Registers are written over APB between
// streams and read back. Both channels are throttled at random, bar one burst.
// ----------------------------------------------------------------------------
module tb_top
    import sswg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASE_W      = 32;
    localparam int TABLE_W      = 10;
    localparam int SAMPLE_W     = 16;
    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 1950;
    localparam int IDLE_PCT     = 33;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic KIND_SINE   = 1'b0;
    localparam logic KIND_SQUARE = 1'b1;

    localparam logic [63:0] POLY_K1       = 64'd102944;
    localparam logic [63:0] POLY_K3       = 64'd42334;
    localparam logic [63:0] POLY_K5       = 64'd4926;
    localparam logic [63:0] Q16_ONE       = 64'd65536;
    localparam logic [63:0] ROUND_HALF    = 64'd32768;
    localparam logic [63:0] SAMPLE_PEAK   = (64'd1 << (SAMPLE_W - 1)) - 64'd1;
    localparam logic [63:0] QUARTER_STEPS = 64'd1 << (TABLE_W - 2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_valid          = 1'b0;
    logic              i_start_of_block = 1'b0;
    logic              i_stall          = 1'b0;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [REG_AW-1:0] paddr            = '0;
    logic [31:0]       pwdata           = '0;
    logic              o_stall;
    logic              o_valid;
    sample_t           o_sample;
    logic [31:0]       prdata;
    logic              pready;

    logic               gen_kind;
    logic [31:0]        gen_tuning;
    logic [14:0]        gen_amp;
    logic [16:0]        gen_duty;
    logic [PHASE_W-1:0] gen_phase;

    sample_t expected_samples[$];
    sample_t want;
    int      fail_count  = 0;
    int      cycle_count = 0;
    bit      throttle    = 1'b1;

    sine_square_waveform_generator #(
        .PHASE_BITS      (PHASE_W),
        .SINE_TABLE_BITS (TABLE_W),
        .SAMPLE_BITS     (SAMPLE_W)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_start_of_block (i_start_of_block),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_sample         (o_sample),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [16:0] quarter_wave(input logic [16:0] x);
        logic [63:0] xx;
        logic [63:0] sq;
        logic [63:0] inner;
        logic [63:0] outer;
        logic [63:0] res;
        xx    = 64'(x);
        sq    = (xx * xx) >> 16;
        inner = POLY_K3 - ((sq * POLY_K5) >> 16);
        outer = POLY_K1 - ((sq * inner) >> 16);
        res   = (xx * outer) >> 16;
        return (res > Q16_ONE) ? Q16_ONE[16:0] : res[16:0];
    endfunction

    function automatic logic [63:0] peak_amp();
        return (64'(gen_amp) > SAMPLE_PEAK) ? SAMPLE_PEAK : 64'(gen_amp);
    endfunction

    function automatic sample_t sine_value(input logic [PHASE_W-1:0] ph);
        logic [TABLE_W-1:0] idx;
        logic [1:0]         quad;
        logic [63:0]        pos;
        logic [63:0]        x;
        logic [63:0]        mag;
        idx  = ph[PHASE_W-1 -: TABLE_W];
        quad = idx[TABLE_W-1 -: 2];
        pos  = 64'(idx[TABLE_W-3:0]);
        x    = quad[0] ? (QUARTER_STEPS - pos) : pos;
        x    = x << (16 - (TABLE_W - 2));
        mag  = (64'(quarter_wave(x[16:0])) * peak_amp() + ROUND_HALF) >> 16;
        if (mag > SAMPLE_PEAK) begin
            mag = SAMPLE_PEAK;
        end
        return quad[1] ? -sample_t'(mag) : sample_t'(mag);
    endfunction

    function automatic sample_t square_value(input logic [PHASE_W-1:0] ph);
        logic [15:0] frac;
        logic [63:0] duty;
        logic [63:0] mag;
        frac = ph[PHASE_W-1 -: 16];
        duty = (64'(gen_duty) > Q16_ONE) ? Q16_ONE : 64'(gen_duty);
        mag  = peak_amp();
        return (64'(frac) < duty) ? sample_t'(mag) : -sample_t'(mag);
    endfunction

    function automatic sample_t next_sample(input logic sob);
        sample_t s;
        if (gen_kind == KIND_SQUARE) begin
            if (sob) begin
                gen_phase = '0;
            end
            s = square_value(gen_phase);
        end else begin
            s = sine_value(gen_phase);
        end
        gen_phase = gen_phase + PHASE_W'(gen_tuning);
        return s;
    endfunction

    function automatic logic [31:0] reg_image(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_WAVEFORM_KIND: return 32'(gen_kind);
            REG_TUNING_WORD:   return gen_tuning;
            REG_AMPLITUDE:     return 32'(gen_amp);
            REG_DUTY_FRACTION: return 32'(gen_duty);
            default:           return '0;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sample checker and receiver throttle
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_samples.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected sample, expected none, actual %0d",
                         $time, o_sample);
            end else begin
                want = expected_samples.pop_front();
                if (o_sample !== want) begin
                    fail_count++;
                    $display("%0t: sample mismatch, expected %0d, actual %0d",
                             $time, want, o_sample);
                end
            end
        end
        i_stall <= throttle && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Request and register access
    // ------------------------------------------------------------------
    task automatic send_tick(input logic sob);
        i_valid          <= 1'b1;
        i_start_of_block <= sob;
        do @(posedge i_clk); while (o_stall);
        expected_samples.push_back(next_sample(sob));
        while (throttle && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        case (idx)
            REG_WAVEFORM_KIND: gen_kind   = value[0];
            REG_TUNING_WORD:   gen_tuning = value;
            REG_AMPLITUDE:     gen_amp    = value[14:0];
            REG_DUTY_FRACTION: gen_duty   = value[16:0];
            default: ;
        endcase
    endtask

    task automatic check_registers();
        logic [REG_IDX_W-1:0] idx;
        logic [31:0]          got;
        wait_idle();
        for (int i = 0; i < 4; i++) begin
            idx     = REG_IDX_W'(i);
            psel    <= 1'b1;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge i_clk);
            penable <= 1'b1;
            do @(posedge i_clk); while (!pready);
            penable <= 1'b0;
            got = prdata;
            if (got !== reg_image(idx)) begin
                fail_count++;
                $display("%0t: register %0d mismatch, expected %0h, actual %0h",
                         $time, i, reg_image(idx), got);
            end
        end
    endtask

    // release the bus before streaming
    task automatic apb_park();
        psel <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_register_defaults();
        check_registers();
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_sine_quadrants();
        write_reg(REG_TUNING_WORD, 32'h3000_0000);
        apb_park();
        for (int i = 0; i < 6; i++) begin
            send_tick(i[0]);
        end
        write_reg(REG_TUNING_WORD, 32'hFFFF_FFFF);
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_zero_tuning();
        write_reg(REG_TUNING_WORD, 32'h0000_0000);
        apb_park();
        send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic test_zero_amplitude();
        write_reg(REG_AMPLITUDE, 32'h0000_0000);
        write_reg(REG_TUNING_WORD, 32'h1234_5678);
        apb_park();
        send_tick(1'b0);
        send_tick(1'b0);
        write_reg(REG_AMPLITUDE, 32'h0000_0001);
        apb_park();
        send_tick(1'b0);
    endtask

    task automatic test_square_duty();
        write_reg(REG_WAVEFORM_KIND, 32'(KIND_SQUARE));
        write_reg(REG_AMPLITUDE, 32'h0000_7FFF);
        write_reg(REG_TUNING_WORD, 32'h4000_0000);
        write_reg(REG_DUTY_FRACTION, 32'h0000_8000);
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b0);
        send_tick(1'b1);
        write_reg(REG_DUTY_FRACTION, 32'h0000_0000);
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(REG_DUTY_FRACTION, 32'h0001_0000);
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
        write_reg(REG_DUTY_FRACTION, 32'h0001_FFFF);
        apb_park();
        send_tick(1'b0);
    endtask

    task automatic test_mode_switch();
        write_reg(REG_WAVEFORM_KIND, 32'(KIND_SINE));
        apb_park();
        send_tick(1'b1);
        send_tick(1'b0);
    endtask

    task automatic test_random_streams();
        int          sent;
        int          run_len;
        int          burst_no;
        logic [31:0] tw;
        logic [14:0] amp;
        logic [16:0] dt;
        sent     = 0;
        burst_no = 0;
        while (sent < RANDOM_ITEMS) begin
            write_reg(REG_WAVEFORM_KIND, {31'($urandom()), 1'($urandom_range(0, 1))});
            case ($urandom_range(0, 5))
                0:       tw = 32'h0000_0000;
                1:       tw = 32'h0000_0001;
                2:       tw = 32'hFFFF_FFFF;
                3:       tw = 32'($urandom_range(1, 255)) << $urandom_range(16, 24);
                4:       tw = 32'($urandom_range(1, 32'h0100_0000));
                default: tw = $urandom();
            endcase
            write_reg(REG_TUNING_WORD, tw);
            case ($urandom_range(0, 4))
                0:       amp = 15'd0;
                1:       amp = 15'd1;
                2:       amp = 15'd32767;
                default: amp = 15'($urandom_range(0, 32767));
            endcase
            write_reg(REG_AMPLITUDE, {17'($urandom()), amp});
            case ($urandom_range(0, 5))
                0:       dt = 17'd0;
                1:       dt = 17'd65536;
                2:       dt = 17'd131071;
                3:       dt = 17'($urandom_range(65537, 131071));
                default: dt = 17'($urandom_range(0, 65536));
            endcase
            write_reg(REG_DUTY_FRACTION, {15'($urandom()), dt});
            check_registers();
            apb_park();
            // one long burst at full rate on both sides
            throttle = (burst_no != 2);
            run_len  = (burst_no == 2) ? 400 : $urandom_range(20, 200);
            repeat (run_len) begin
                if (gen_kind == KIND_SQUARE) begin
                    send_tick($urandom_range(0, 15) == 0);
                end else begin
                    send_tick(1'($urandom_range(0, 1)));
                end
                sent++;
            end
            burst_no++;
        end
        throttle = 1'b1;
    endtask

    initial begin
        int waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        gen_kind   = RST_WAVEFORM_KIND;
        gen_tuning = RST_TUNING_WORD;
        gen_amp    = RST_AMPLITUDE;
        gen_duty   = RST_DUTY_FRACTION;
        gen_phase  = '0;

        test_register_defaults();
        test_sine_quadrants();
        test_zero_tuning();
        test_zero_amplitude();
        test_square_duty();
        test_mode_switch();
        test_random_streams();

        i_valid <= 1'b0;
        waited = 0;
        while (expected_samples.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_samples.size() != 0) begin
            fail_count++;
            $display("%0t: %0d samples missing, expected %0d, actual none",
                     $time, expected_samples.size(), expected_samples[0]);
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sswg_pkg.sv
sv/sine_square_waveform_generator.sv
dv/tb_top.sv
